@@ rtl/nlsl_pkg.sv @@
`default_nettype none

package nlsl_pkg;

	localparam int CAPACITY = 8;

	localparam int ID_W   = 16;
	localparam int DIST_W = 32;
	localparam int SLOT_W = 3;
	localparam int REQ_W  = 3;
	localparam int STAT_W = 3;
	localparam int ECNT_W = 4;

	localparam int POS_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	// Cell positions and slot indexes are compared at this common width.
	localparam int CMP_W = (POS_W > SLOT_W) ? POS_W : SLOT_W;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 56;

	localparam logic [REQ_W-1:0] REQ_INSERT    = 3'd0;
	localparam logic [REQ_W-1:0] REQ_REMOVE_ID = 3'd1;
	localparam logic [REQ_W-1:0] REQ_REMOVE_AT = 3'd2;
	localparam logic [REQ_W-1:0] REQ_CLEAR     = 3'd3;
	localparam logic [REQ_W-1:0] REQ_READ      = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
	localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
	localparam logic [STAT_W-1:0] ST_DUP       = 3'd2;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
	localparam logic [STAT_W-1:0] ST_RANGE     = 3'd4;

	typedef struct packed {
		logic              valid;
		logic [ID_W-1:0]   id;
		logic [DIST_W-1:0] distance;
	} nlsl_entry_t;

	// Broadcast to every cell; the do_* strobes are already qualified.
	typedef struct packed {
		logic              do_insert;
		logic              do_rm_id;
		logic              do_rm_at;
		logic              do_clear;
		logic [ID_W-1:0]   light_id;
		logic [DIST_W-1:0] distance_sq;
		logic [CMP_W-1:0]  slot_index;
	} nlsl_cmd_t;

endpackage

`default_nettype wire

@@ rtl/nlsl_cell.sv @@
`default_nettype none

module nlsl_cell
	import nlsl_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [CMP_W-1:0] pos,
	input  wire nlsl_cmd_t   cmd,
	input  wire nlsl_entry_t left_ent,
	input  wire logic        left_gt,
	input  wire logic        left_seen,
	input  wire nlsl_entry_t right_ent,
	output nlsl_entry_t      ent,
	output logic             gt,
	output logic             seen,
	output logic             match
);

	logic              valid_q;
	logic [ID_W-1:0]   id_q;
	logic [DIST_W-1:0] dist_q;
	nlsl_entry_t       nxt;

	// Empty cells count as farther than anything, so an insert lands after the last entry.
	assign gt    = !valid_q || (cmd.distance_sq < dist_q);
	assign match = valid_q && (id_q == cmd.light_id);
	assign seen  = left_seen || match;

	assign ent.valid    = valid_q;
	assign ent.id       = id_q;
	assign ent.distance = dist_q;

	always_comb begin
		nxt = ent;
		priority if (cmd.do_clear) begin
			nxt.valid = 1'b0;
		end else if (cmd.do_insert) begin
			if (left_gt) begin
				nxt = left_ent;
			end else if (gt) begin
				nxt.valid    = 1'b1;
				nxt.id       = cmd.light_id;
				nxt.distance = cmd.distance_sq;
			end
		end else if (cmd.do_rm_id) begin
			if (seen) begin
				nxt = right_ent;
			end
		end else if (cmd.do_rm_at) begin
			if (pos >= cmd.slot_index) begin
				nxt = right_ent;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		id_q   <= nxt.id;
		dist_q <= nxt.distance;
	end

endmodule

`default_nettype wire

@@ rtl/nearest_light_sorted_list.sv @@
// Channel  Dir  tdata (low bit first)                          tuser
// s_*      in   light_id[15:0], distance_sq[47:16],            req_type[2:0]
//               slot_index[50:48], zero fill to 56
// m_*      out  entry_count[3:0], read_id[19:4],               status[2:0]
//               read_distance[51:20], zero fill to 56
//
// One request per cycle: every cell compares and shifts in the cycle the beat is accepted,
// and the result is held in one output register.
// The critical path runs along the chain of cells for remove by id (match seen so far).
// Reset empties every cell at once; no clearing pass is needed.
// A result waiting on m_tready stalls s_tready only while the output register cannot drain.
`default_nettype none

module nearest_light_sorted_list
	import nlsl_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,  // light_id, distance_sq, slot_index
	input  wire logic [REQ_W-1:0]      s_tuser,  // req_type
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,  // entry_count, read_id, read_distance
	output logic [STAT_W-1:0]          m_tuser   // status
);

	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic [STAT_W-1:0]     m_tuser_q;
	logic [CNT_W-1:0]      count_q;

	logic                  accept;
	logic [REQ_W-1:0]      req_type;
	logic [ID_W-1:0]       light_id;
	logic [DIST_W-1:0]     distance_sq;
	logic [SLOT_W-1:0]     slot_index;

	nlsl_cmd_t             cmd;
	nlsl_entry_t           cell_ent [CAPACITY];
	logic [CAPACITY-1:0]   cell_valid;
	logic [CAPACITY-1:0]   gt_w;
	logic [CAPACITY-1:0]   seen_w;
	logic [CAPACITY-1:0]   match_w;

	logic                  full;
	logic                  found;
	nlsl_entry_t           rd_ent;
	logic                  rd_hit;
	logic [STAT_W-1:0]     status;
	logic [CNT_W-1:0]      count_nx;
	logic [CNT_W+ECNT_W-1:0] cnt_wide;
	logic [ID_W-1:0]       rd_id;
	logic [DIST_W-1:0]     rd_dist;

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign req_type    = s_tuser;
	assign light_id    = s_tdata[ID_W-1:0];
	assign distance_sq = s_tdata[ID_W+DIST_W-1:ID_W];
	assign slot_index  = s_tdata[ID_W+DIST_W+SLOT_W-1:ID_W+DIST_W];

	assign full  = cell_ent[CAPACITY-1].valid;
	assign found = |match_w;

	always_comb begin
		cmd             = '0;
		cmd.light_id    = light_id;
		cmd.distance_sq = distance_sq;
		cmd.slot_index  = CMP_W'(slot_index);
		cmd.do_insert   = accept && (req_type == REQ_INSERT) && !full && !found;
		cmd.do_rm_id    = accept && (req_type == REQ_REMOVE_ID);
		cmd.do_rm_at    = accept && (req_type == REQ_REMOVE_AT) && rd_hit;
		cmd.do_clear    = accept && (req_type == REQ_CLEAR);
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		nlsl_entry_t left_ent;
		nlsl_entry_t right_ent;
		logic        left_gt;
		logic        left_seen;

		if (i == 0) begin : g_head
			assign left_ent  = '0;
			assign left_gt   = 1'b0;
			assign left_seen = 1'b0;
		end else begin : g_body
			assign left_ent  = cell_ent[i-1];
			assign left_gt   = gt_w[i-1];
			assign left_seen = seen_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_ent = '0;
		end else begin : g_next
			assign right_ent = cell_ent[i+1];
		end

		nlsl_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.pos       (CMP_W'(i)),
			.cmd       (cmd),
			.left_ent  (left_ent),
			.left_gt   (left_gt),
			.left_seen (left_seen),
			.right_ent (right_ent),
			.ent       (cell_ent[i]),
			.gt        (gt_w[i]),
			.seen      (seen_w[i]),
			.match     (match_w[i])
		);

		assign cell_valid[i] = cell_ent[i].valid;
	end

	// Valid cells form a prefix, so a slot is in range exactly when its cell is valid.
	always_comb begin
		rd_ent = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (CMP_W'(i) == CMP_W'(slot_index)) begin
				rd_ent = cell_ent[i];
			end
		end
	end
	assign rd_hit = rd_ent.valid;

	always_comb begin
		status   = ST_OK;
		count_nx = count_q;
		rd_id    = '0;
		rd_dist  = '0;
		unique case (req_type)
			REQ_INSERT: begin
				if (full) begin
					status = ST_FULL;
				end else if (found) begin
					status = ST_DUP;
				end else begin
					count_nx = count_q + CNT_W'(1);
				end
			end
			REQ_REMOVE_ID: begin
				if (found) begin
					count_nx = count_q - CNT_W'(1);
				end else begin
					status = ST_NOT_FOUND;
				end
			end
			REQ_REMOVE_AT: begin
				if (rd_hit) begin
					count_nx = count_q - CNT_W'(1);
				end else begin
					status = ST_RANGE;
				end
			end
			REQ_CLEAR: begin
				count_nx = '0;
			end
			REQ_READ: begin
				if (rd_hit) begin
					rd_id   = rd_ent.id;
					rd_dist = rd_ent.distance;
				end else begin
					status = ST_RANGE;
				end
			end
			default: begin
				status = ST_OK;
			end
		endcase
	end

	assign cnt_wide = {{ECNT_W{1'b0}}, count_nx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			count_q    <= '0;
		end else begin
			if (accept) begin
				m_tvalid_q <= 1'b1;
				count_q    <= count_nx;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q <= OUT_DATA_W'({rd_dist, rd_id, cnt_wide[ECNT_W-1:0]});
			m_tuser_q <= status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	a_count_tracks_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_valid) == 32'(count_q))
		else $error("entry count disagrees with occupied cells");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req_type == REQ_CLEAR) |=> (count_q == '0) && (cell_valid == '0))
		else $error("clear left entries behind");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_insert |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("successful insert did not add one entry");

	a_beat_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> m_tvalid)
		else $error("accepted beat produced no result");

endmodule

`default_nettype wire

@@ tb/nearest_light_sorted_list_checker.sv @@
`timescale 1ns / 100ps

module nearest_light_sorted_list_checker
	import nlsl_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [REQ_W-1:0]      s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	input  logic [STAT_W-1:0]     m_tuser,
	output int                    mismatches,
	output int                    outstanding
);

	localparam int MAX_REPORTS = 40;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [ECNT_W-1:0] entries;
		logic [ID_W-1:0]   rd_id;
		logic [DIST_W-1:0] rd_dist;
	} list_reply_t;

	// Shadow copy of the list, nearest light first.
	logic [ID_W-1:0]   slot_id   [CAPACITY];
	logic [DIST_W-1:0] slot_dist [CAPACITY];
	int                filled;

	list_reply_t due_replies[$];
	list_reply_t want;
	int          errors = 0;

	function automatic void empty_list();
		for (int i = 0; i < CAPACITY; i++) begin
			slot_id[i]   = '0;
			slot_dist[i] = '1;
		end
		filled = 0;
	endfunction

	function automatic int find_light(logic [ID_W-1:0] id);
		for (int i = 0; i < filled; i++) begin
			if (slot_id[i] == id)
				return i;
		end
		return -1;
	endfunction

	function automatic void drop_at(int pos);
		for (int i = pos + 1; i < filled; i++) begin
			slot_id[i-1]   = slot_id[i];
			slot_dist[i-1] = slot_dist[i];
		end
		slot_id[filled-1]   = '0;
		slot_dist[filled-1] = '1;
		filled--;
	endfunction

	function automatic list_reply_t apply_request(logic [REQ_W-1:0] req, logic [ID_W-1:0] id,
			logic [DIST_W-1:0] dist_sq, logic [SLOT_W-1:0] idx);
		list_reply_t r;
		int          hit;
		int          pos;
		r.status  = ST_OK;
		r.rd_id   = '0;
		r.rd_dist = '0;
		case (req)
			REQ_INSERT: begin
				if (filled >= CAPACITY) begin
					r.status = ST_FULL;
				end else if (find_light(id) >= 0) begin
					r.status = ST_DUP;
				end else begin
					// Entries strictly farther than the new one form a tail; shift it back.
					pos = filled;
					while (pos > 0 && slot_dist[pos-1] > dist_sq) begin
						slot_id[pos]   = slot_id[pos-1];
						slot_dist[pos] = slot_dist[pos-1];
						pos--;
					end
					slot_id[pos]   = id;
					slot_dist[pos] = dist_sq;
					filled++;
				end
			end
			REQ_REMOVE_ID: begin
				hit = find_light(id);
				if (hit < 0)
					r.status = ST_NOT_FOUND;
				else
					drop_at(hit);
			end
			REQ_REMOVE_AT: begin
				if (int'(idx) < filled)
					drop_at(int'(idx));
				else
					r.status = ST_RANGE;
			end
			REQ_CLEAR: begin
				empty_list();
			end
			REQ_READ: begin
				if (int'(idx) < filled) begin
					r.rd_id   = slot_id[idx];
					r.rd_dist = slot_dist[idx];
				end else begin
					r.status = ST_RANGE;
				end
			end
			default: begin
			end
		endcase
		r.entries = ECNT_W'(filled);
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
		if (errors < MAX_REPORTS)
			$display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_list();
			due_replies.delete();
		end else begin
			if (s_tvalid && s_tready)
				due_replies.push_back(apply_request(s_tuser, s_tdata[ID_W-1:0],
					s_tdata[ID_W +: DIST_W], s_tdata[ID_W+DIST_W +: SLOT_W]));
			if (m_tvalid && m_tready) begin
				if (due_replies.size() == 0) begin
					report_mismatch("result beat with nothing expected", 64'(m_tdata), '0);
				end else begin
					want = due_replies.pop_front();
					if (m_tuser != want.status)
						report_mismatch("status", 64'(m_tuser), 64'(want.status));
					if (m_tdata[ECNT_W-1:0] != want.entries)
						report_mismatch("entry_count", 64'(m_tdata[ECNT_W-1:0]),
							64'(want.entries));
					if (m_tdata[ECNT_W +: ID_W] != want.rd_id)
						report_mismatch("read_id", 64'(m_tdata[ECNT_W +: ID_W]),
							64'(want.rd_id));
					if (m_tdata[ECNT_W+ID_W +: DIST_W] != want.rd_dist)
						report_mismatch("read_distance", 64'(m_tdata[ECNT_W+ID_W +: DIST_W]),
							64'(want.rd_dist));
				end
			end
		end
		outstanding <= due_replies.size();
		mismatches  <= errors;
	end

endmodule

@@ tb/nearest_light_sorted_list_tb.sv @@
`timescale 1ns / 100ps

module nearest_light_sorted_list_tb;
	import nlsl_pkg::*;

	localparam int STALL_LIMIT  = 1000;
	localparam int HOLD_CYCLES  = 150;
	localparam int RANDOM_ITEMS = 700;
	localparam int BLOCK_ITEMS  = 100;

	// Request codes the block treats as no operation.
	localparam logic [REQ_W-1:0] REQ_SPARE_FIRST = 3'd5;
	localparam logic [REQ_W-1:0] REQ_SPARE_LAST  = 3'd7;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;
	logic [REQ_W-1:0]      s_tuser  = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [STAT_W-1:0]     m_tuser;

	int mismatches;
	int outstanding;
	int idle_cycles  = 0;
	bit source_idle  = 1'b0;
	bit sink_idle    = 1'b0;
	bit long_hold    = 1'b0;
	bit hold_done    = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	nearest_light_sorted_list dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	nearest_light_sorted_list_checker list_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Result side: random back-pressure, plus one long hold on request.
	initial begin
		int gap;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (long_hold && !hold_done) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				gap = sink_idle ? $urandom_range(0, 4) : 0;
				if (gap > 0) begin
					m_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				m_tready <= 1'b1;
				do @(posedge clk); while (!m_tvalid);
			end
		end
	end

	task automatic issue_request(logic [REQ_W-1:0] req, logic [ID_W-1:0] id,
			logic [DIST_W-1:0] dist_sq, logic [SLOT_W-1:0] idx);
		int gap;
		gap = source_idle ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= IN_DATA_W'({idx, dist_sq, id});
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// Mostly a small pool so duplicates and removals by id hit often.
	function automatic logic [ID_W-1:0] pick_light_id();
		logic [ID_W-1:0] id;
		if ($urandom_range(0, 9) == 0)
			return ID_W'($urandom);
		id = ID_W'($urandom_range(0, 11));
		if ($urandom_range(0, 3) == 0)
			id[ID_W-1] = 1'b1;
		return id;
	endfunction

	function automatic logic [DIST_W-1:0] pick_distance();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3, 4: return DIST_W'($urandom_range(0, 7));
			default: return DIST_W'($urandom);
		endcase
	endfunction

	task automatic random_request();
		int          roll;
		logic [SLOT_W-1:0] idx;
		roll = $urandom_range(0, 99);
		idx  = SLOT_W'($urandom_range(0, 7));
		if (roll < 40)
			issue_request(REQ_INSERT, pick_light_id(), pick_distance(), idx);
		else if (roll < 55)
			issue_request(REQ_REMOVE_ID, pick_light_id(), DIST_W'($urandom), idx);
		else if (roll < 67)
			issue_request(REQ_REMOVE_AT, ID_W'($urandom), DIST_W'($urandom), idx);
		else if (roll < 92)
			issue_request(REQ_READ, ID_W'($urandom), DIST_W'($urandom), idx);
		else if (roll < 95)
			issue_request(REQ_CLEAR, ID_W'($urandom), DIST_W'($urandom), idx);
		else
			issue_request(REQ_SPARE_FIRST + REQ_W'($urandom_range(0, 2)), ID_W'($urandom),
				DIST_W'($urandom), idx);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty list, ordering with ties, full and duplicate checks.
		sink_idle = 1'b1;
		issue_request(REQ_READ, '0, '0, '0);
		issue_request(REQ_REMOVE_ID, 16'h1234, '0, '0);
		issue_request(REQ_REMOVE_AT, '0, '0, '0);
		issue_request(REQ_INSERT, '0, '0, '0);
		issue_request(REQ_INSERT, '1, '1, '1);
		issue_request(REQ_INSERT, 16'd5, 32'd100, '0);
		issue_request(REQ_INSERT, 16'd6, 32'd100, '0);
		issue_request(REQ_INSERT, 16'd5, 32'd1, '0);
		issue_request(REQ_INSERT, 16'd7, 32'd50, '0);
		issue_request(REQ_INSERT, 16'd8, 32'd100, '0);
		issue_request(REQ_INSERT, 16'd9, '1, '0);
		issue_request(REQ_INSERT, 16'd10, 32'd1, '0);
		issue_request(REQ_INSERT, 16'd11, '0, '0);
		issue_request(REQ_INSERT, 16'd5, 32'd3, '0);
		issue_request(REQ_READ, '0, '0, 3'd0);
		issue_request(REQ_READ, '0, '0, 3'd7);
		issue_request(REQ_REMOVE_AT, '0, '0, 3'd7);
		issue_request(REQ_REMOVE_AT, '0, '0, 3'd0);
		issue_request(REQ_REMOVE_ID, '1, '0, '0);
		issue_request(REQ_READ, '0, '0, 3'd7);
		issue_request(REQ_SPARE_FIRST, '1, '1, '1);
		issue_request(REQ_SPARE_LAST, '1, '1, '1);
		issue_request(REQ_CLEAR, '1, '1, '1);
		issue_request(REQ_READ, '0, '0, 3'd0);
		wait_drained();

		for (int blk = 0; blk * BLOCK_ITEMS < RANDOM_ITEMS; blk++) begin
			source_idle = (blk != 1) && ($urandom_range(0, 3) != 0);
			sink_idle   = (blk != 1) && ($urandom_range(0, 3) != 0);
			// One block runs against a stalled receiver so the input side backs up.
			if (blk == 3) begin
				source_idle = 1'b0;
				long_hold   = 1'b1;
			end
			for (int n = 0; n < BLOCK_ITEMS; n++)
				random_request();
			if (blk % 2 == 0)
				wait_drained();
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
